@@ rtl/core/bsdg_pkg.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid package
// Shared widths, register codes and the structs passed between the datapath
// modules of the box signed distance grid.
// ----------------------------------------------------------------------------
package bsdg_pkg;

	localparam int IDX_W     = 6;
	localparam int HALF_W    = 31;
	localparam int ORIG_W    = 32;
	localparam int STEP_W    = 31;
	localparam int DIST_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MAG_W     = 31;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int N_AXES    = 3;

	localparam logic [DIST_W-1:0] DIST_MAX = 32'h7FFF_FFFF;

	localparam logic [HALF_W-1:0] HALF_RESET = 31'd65536;
	localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_SIZE = 3'd0,
		REG_ORIGIN_X  = 3'd1,
		REG_ORIGIN_Y  = 3'd2,
		REG_ORIGIN_Z  = 3'd3,
		REG_STEP_X    = 3'd4,
		REG_STEP_Y    = 3'd5,
		REG_STEP_Z    = 3'd6
	} cfg_reg_t;

	// Per-axis result of the clamp stage.
	typedef struct packed {
		logic              clamped;
		logic              big;
		logic              csat;
		logic [MAG_W-1:0]  mag;
		logic [HALF_W-1:0] abs_s;
	} axis_res_t;

	// Sideband carried alongside the square root pipeline.
	typedef struct packed {
		logic                     outside;
		logic                     big;
		logic                     sat;
		logic signed [DIST_W-1:0] dist_in;
	} side_t;

	// One finished result.
	typedef struct packed {
		logic [DIST_W-1:0] dist_val;
		logic              outside;
		logic              sat;
	} res_t;

endpackage

@@ rtl/core/bsdg_axis.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid, per-axis front end
// Three pipeline stages: grid position product, origin offset with coordinate
// saturation, and clamping against the cube half size.
// ----------------------------------------------------------------------------
module bsdg_axis import bsdg_pkg::*; #(
	parameter int GRID_SIZE  = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [IDX_W-1:0]         idx,
	input  logic [STEP_W-1:0]        step,
	input  logic signed [ORIG_W-1:0] origin,
	input  logic [HALF_W-1:0]        half,
	output axis_res_t                res
);

	localparam int IDX_TOP = (1 << IDX_W) - 1;
	localparam int IDX_MAX = (GRID_SIZE - 1 < IDX_TOP) ? GRID_SIZE - 1 : IDX_TOP;
	localparam logic [IDX_W-1:0] IDX_LIM = IDX_W'(IDX_MAX);
	localparam int PROD_W = IDX_W + STEP_W;
	localparam int PS_W   = PROD_W + 2;
	localparam int XW     = ((PS_W > COORD_BITS) ? PS_W : COORD_BITS) + 1;
	localparam longint P_HI_L = (longint'(1) <<< (COORD_BITS - 1)) - 1;
	localparam logic signed [XW-1:0] P_HI = XW'(P_HI_L);
	localparam logic signed [XW-1:0] P_LO = XW'(-P_HI_L - 1);
	localparam int EW = ((COORD_BITS > ORIG_W) ? COORD_BITS : ORIG_W) + 2;
	localparam logic signed [EW-1:0] ZERO_E = '0;

	logic [IDX_W-1:0]              idx_c;
	logic [PROD_W-1:0]             prod_s1;
	logic signed [PS_W-1:0]        psum;
	logic signed [XW-1:0]          pwide;
	logic signed [COORD_BITS-1:0]  p_s2;
	logic                          csat_s2;
	logic signed [EW-1:0]          pe;
	logic signed [EW-1:0]          he;
	logic signed [EW-1:0]          dm_hi;
	logic signed [EW-1:0]          dm_lo;
	logic signed [EW-1:0]          pneg;
	axis_res_t                     res_s3;

	// Stage 1: index limit and position product.
	assign idx_c = (idx > IDX_LIM) ? IDX_LIM : idx;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(idx_c) * PROD_W'(step);
		end
	end

	// Stage 2: add the origin and saturate to the coordinate range.
	assign psum  = $signed({{(PS_W - ORIG_W){origin[ORIG_W-1]}}, origin})
		+ $signed({2'b00, prod_s1});
	assign pwide = $signed({{(XW - PS_W){psum[PS_W-1]}}, psum});

	always_ff @(posedge clk) begin
		if (en) begin
			if (pwide > P_HI) begin
				p_s2    <= P_HI[COORD_BITS-1:0];
				csat_s2 <= 1'b1;
			end else if (pwide < P_LO) begin
				p_s2    <= P_LO[COORD_BITS-1:0];
				csat_s2 <= 1'b1;
			end else begin
				p_s2    <= pwide[COORD_BITS-1:0];
				csat_s2 <= 1'b0;
			end
		end
	end

	// Stage 3: clamp to the cube and take the distance beyond the face.
	assign pe    = $signed({{(EW - COORD_BITS){p_s2[COORD_BITS-1]}}, p_s2});
	assign he    = $signed({{(EW - HALF_W){1'b0}}, half});
	assign dm_hi = pe - he;
	assign dm_lo = ZERO_E - he - pe;
	assign pneg  = ZERO_E - pe;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.csat <= csat_s2;
			if (pe > he) begin
				res_s3.clamped <= 1'b1;
				res_s3.big     <= (dm_hi[EW-1:MAG_W] != '0);
				res_s3.mag     <= dm_hi[MAG_W-1:0];
				res_s3.abs_s   <= half;
			end else if (dm_lo > ZERO_E) begin
				res_s3.clamped <= 1'b1;
				res_s3.big     <= (dm_lo[EW-1:MAG_W] != '0);
				res_s3.mag     <= dm_lo[MAG_W-1:0];
				res_s3.abs_s   <= half;
			end else begin
				res_s3.clamped <= 1'b0;
				res_s3.big     <= 1'b0;
				res_s3.mag     <= '0;
				res_s3.abs_s   <= pe[EW-1] ? pneg[HALF_W-1:0] : pe[HALF_W-1:0];
			end
		end
	end

	assign res = res_s3;

endmodule

@@ rtl/core/bsdg_isqrt.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid, pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage, truncated result.
// ----------------------------------------------------------------------------
module bsdg_isqrt import bsdg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SUM_W-1:0]  radicand,
	input  side_t             side_in,
	output logic [ROOT_W-1:0] root,
	output side_t             side_out
);

	logic [SUM_W-1:0]  rem_s  [ROOT_W-1];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	side_t             side_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_step
		localparam int K = ROOT_W - 1 - g;

		logic [SUM_W-1:0]  rem_in;
		logic [SUM_W-1:0]  trial;
		logic [ROOT_W-1:0] root_in;
		side_t             sd_in;
		logic              take;

		if (g == 0) begin : g_first
			assign rem_in  = radicand;
			assign root_in = '0;
			assign sd_in   = side_in;
		end else begin : g_next
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign sd_in   = side_s[g-1];
		end

		// Bits of the partial root all lie above K, so the OR is an add.
		assign trial = (SUM_W'(root_in) << (K + 1)) | (SUM_W'(1) << (2 * K));
		assign take  = (rem_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
				side_s[g] <= sd_in;
			end
		end

		if (g < ROOT_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= take ? (rem_in - trial) : rem_in;
				end
			end
		end
	end

	assign root     = root_s[ROOT_W-1];
	assign side_out = side_s[ROOT_W-1];

endmodule

@@ rtl/core/box_signed_distance_grid.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid
// Signed distance from voxel grid points to an origin-centered cube, Q16.16.
// ----------------------------------------------------------------------------
// The block takes voxel index triples and returns one signed distance per
// item, in the order the items were accepted. Each item passes from
// acceptance to the output register through the per-axis front end (grid
// position product, origin add with coordinate saturation, clamp against
// the cube), a stage for the squares of the per-axis overshoot, a stage for
// their sum and the inside distance, and the square root, which resolves
// one root bit per stage. The sustained rate is one item per clock while
// in_stall is low. The output side is a two-entry queue, so a result that
// waits on out_stall does not hold up the input; in_stall rises only once
// both entries are full, and then the whole pipeline holds its contents
// until the head entry is taken. Configuration registers are written
// through cfg_write, cfg_index and cfg_data and must only be changed while
// no item is in flight. Points exactly on the surface count as inside with
// a distance of zero; distances beyond the 32-bit signed range are
// reported as the largest positive value with saturated set, which is also
// set whenever a grid coordinate overflowed its range.
// ----------------------------------------------------------------------------
module box_signed_distance_grid import bsdg_pkg::*; #(
	parameter int GRID_SIZE  = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,

	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [IDX_W-1:0]         voxel_x,
	input  logic [IDX_W-1:0]         voxel_y,
	input  logic [IDX_W-1:0]         voxel_z,

	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DIST_W-1:0] distance,
	output logic                     outside,
	output logic                     saturated
);

	// Front end takes three stages, then squares and sum, then the root.
	localparam int N_STAGES = 5 + ROOT_W;

	// Configuration registers.
	logic [HALF_W-1:0]        half_q;
	logic signed [ORIG_W-1:0] origin_q [N_AXES];
	logic [STEP_W-1:0]        step_q   [N_AXES];

	// Pipeline control: one valid bit per stage, one enable for all stages.
	logic [N_STAGES:1] valid_q;
	logic              en;

	logic [IDX_W-1:0]  vox [N_AXES];
	axis_res_t         ax  [N_AXES];

	logic [SQ_W-1:0]   sq_s4 [N_AXES];
	logic [HALF_W-1:0] maxabs_s4;
	logic              outside_s4;
	logic              big_s4;
	logic              sat_s4;
	logic [HALF_W-1:0] max01;
	logic [HALF_W-1:0] max012;

	logic [SUM_W-1:0]  sum_s5;
	side_t             side_s5;

	logic [ROOT_W-1:0] root_o;
	side_t             side_o;

	res_t              res_new;
	res_t              head_q;
	res_t              spare_q;
	logic              head_vld_q;
	logic              spare_vld_q;
	logic              push;
	logic              pop;

	// ------------------------------------------------------------------
	// Configuration writes. Codes outside the register list are ignored.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			for (int a = 0; a < N_AXES; a++) begin
				origin_q[a] <= '0;
				step_q[a]   <= STEP_RESET;
			end
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HALF_SIZE: half_q      <= cfg_data[HALF_W-1:0];
				REG_ORIGIN_X:  origin_q[0] <= cfg_data[ORIG_W-1:0];
				REG_ORIGIN_Y:  origin_q[1] <= cfg_data[ORIG_W-1:0];
				REG_ORIGIN_Z:  origin_q[2] <= cfg_data[ORIG_W-1:0];
				REG_STEP_X:    step_q[0]   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:    step_q[1]   <= cfg_data[STEP_W-1:0];
				REG_STEP_Z:    step_q[2]   <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline advance. The pipeline moves as long as the output queue
	// has room for whatever leaves the last stage, so a stalled result
	// never blocks accepting new items on its own.
	// ------------------------------------------------------------------
	assign en       = ~spare_vld_q;
	assign in_stall = spare_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[N_STAGES-1:1], in_valid};
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 3: one front end per axis.
	// ------------------------------------------------------------------
	assign vox[0] = voxel_x;
	assign vox[1] = voxel_y;
	assign vox[2] = voxel_z;

	for (genvar a = 0; a < N_AXES; a++) begin : g_axis
		bsdg_axis #(
			.GRID_SIZE  (GRID_SIZE),
			.COORD_BITS (COORD_BITS)
		) u_axis (
			.clk    (clk),
			.en     (en),
			.idx    (vox[a]),
			.step   (step_q[a]),
			.origin (origin_q[a]),
			.half   (half_q),
			.res    (ax[a])
		);
	end

	// ------------------------------------------------------------------
	// Stage 4: square the overshoot on each axis, find the largest
	// coordinate magnitude and merge the per-axis flags.
	// ------------------------------------------------------------------
	assign max01  = (ax[0].abs_s > ax[1].abs_s) ? ax[0].abs_s : ax[1].abs_s;
	assign max012 = (max01 > ax[2].abs_s) ? max01 : ax[2].abs_s;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < N_AXES; a++) begin
				sq_s4[a] <= SQ_W'(ax[a].mag) * SQ_W'(ax[a].mag);
			end
			maxabs_s4  <= max012;
			outside_s4 <= ax[0].clamped | ax[1].clamped | ax[2].clamped;
			big_s4     <= ax[0].big | ax[1].big | ax[2].big;
			sat_s4     <= ax[0].csat | ax[1].csat | ax[2].csat;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sum of squares for the root, and the inside distance,
	// which is the largest coordinate magnitude less the half size.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5          <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			side_s5.outside <= outside_s4;
			side_s5.big     <= big_s4;
			side_s5.sat     <= sat_s4;
			side_s5.dist_in <= $signed({1'b0, maxabs_s4}) - $signed({1'b0, half_q});
		end
	end

	// ------------------------------------------------------------------
	// Stages 6 to 37: square root, one bit per stage.
	// ------------------------------------------------------------------
	bsdg_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s5),
		.side_in  (side_s5),
		.root     (root_o),
		.side_out (side_o)
	);

	// Pick the outside or inside distance and apply saturation.
	always_comb begin
		res_new.outside = side_o.outside;
		if (side_o.outside) begin
			if (side_o.big || root_o[ROOT_W-1]) begin
				res_new.dist_val = DIST_MAX;
				res_new.sat      = 1'b1;
			end else begin
				res_new.dist_val = DIST_W'(root_o);
				res_new.sat      = side_o.sat;
			end
		end else begin
			res_new.dist_val = side_o.dist_in;
			res_new.sat      = side_o.sat;
		end
	end

	// ------------------------------------------------------------------
	// Output queue: a head entry that drives the ports and a spare entry
	// that catches the item leaving the pipeline while the head waits.
	// ------------------------------------------------------------------
	assign push = valid_q[N_STAGES] & en;
	assign pop  = head_vld_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q  <= 1'b0;
			spare_vld_q <= 1'b0;
		end else begin
			if (push && !pop) begin
				if (!head_vld_q) begin
					head_vld_q <= 1'b1;
				end else begin
					spare_vld_q <= 1'b1;
				end
			end else if (pop && !push) begin
				if (spare_vld_q) begin
					spare_vld_q <= 1'b0;
				end else begin
					head_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && spare_vld_q) begin
			head_q <= spare_q;
		end else if (push && (!head_vld_q || pop)) begin
			head_q <= res_new;
		end
		if (push && head_vld_q && (!pop || spare_vld_q)) begin
			spare_q <= res_new;
		end
	end

	assign out_valid = head_vld_q;
	assign distance  = head_q.dist_val;
	assign outside   = head_q.outside;
	assign saturated = head_q.sat;

endmodule

@@ test/box_signed_distance_grid_checker.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid checker
// Watches the register port and both item channels of the distance block,
// computes the distance expected for every accepted voxel and compares each
// returned result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module box_signed_distance_grid_checker import bsdg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,

	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [IDX_W-1:0]         voxel_x,
	input  logic [IDX_W-1:0]         voxel_y,
	input  logic [IDX_W-1:0]         voxel_z,

	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [DIST_W-1:0] distance,
	input  logic                     outside,
	input  logic                     saturated,

	output int                       mismatches,
	output int                       expected_left
);

	localparam longint COORD_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint COORD_LO = -64'sh0000_0000_8000_0000;
	localparam longint DIST_HI  = 64'sh0000_0000_7FFF_FFFF;

	typedef struct {
		logic signed [DIST_W-1:0] dist_val;
		logic                     outside;
		logic                     sat;
	} cube_dist_t;

	longint     half_len;
	longint     corner[N_AXES];
	longint     spacing[N_AXES];
	cube_dist_t pending_dist[$];
	cube_dist_t oldest;
	int         results_seen;

	// Largest r with r*r <= v, found one bit at a time from the top.
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic cube_dist_t cube_distance(input logic [IDX_W-1:0] vx,
			input logic [IDX_W-1:0] vy, input logic [IDX_W-1:0] vz);
		logic [IDX_W-1:0] idx[N_AXES];
		longint           pos;
		longint           clp;
		longint           diff;
		longint           far_abs;
		longint           dist_val;
		longint unsigned  mag;
		longint unsigned  sq_sum;
		longint unsigned  root;
		logic             beyond;
		logic             sat;
		logic             big;
		cube_dist_t       res;
		idx[0] = vx;
		idx[1] = vy;
		idx[2] = vz;
		beyond = 1'b0;
		sat = 1'b0;
		big = 1'b0;
		far_abs = 0;
		sq_sum = 0;
		for (int c = 0; c < N_AXES; c++) begin
			pos = corner[c] + longint'(idx[c]) * spacing[c];
			if (pos > COORD_HI) begin
				pos = COORD_HI;
				sat = 1'b1;
			end else if (pos < COORD_LO) begin
				pos = COORD_LO;
				sat = 1'b1;
			end
			clp = pos;
			if (clp < -half_len) begin
				clp = -half_len;
				beyond = 1'b1;
			end else if (clp > half_len) begin
				clp = half_len;
				beyond = 1'b1;
			end
			diff = pos - clp;
			if (diff > DIST_HI || diff < -DIST_HI)
				big = 1'b1;
			mag = (diff < 0) ? -diff : diff;
			sq_sum += mag * mag;
			if (clp < 0)
				clp = -clp;
			if (clp > far_abs)
				far_abs = clp;
		end
		if (!beyond) begin
			dist_val = far_abs - half_len;
		end else if (big) begin
			dist_val = DIST_HI;
			sat = 1'b1;
		end else begin
			root = floor_root(sq_sum);
			if (root > DIST_HI) begin
				dist_val = DIST_HI;
				sat = 1'b1;
			end else begin
				dist_val = longint'(root);
			end
		end
		res.dist_val = dist_val[DIST_W-1:0];
		res.outside = beyond;
		res.sat = sat;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_len = longint'(HALF_RESET);
			for (int c = 0; c < N_AXES; c++) begin
				corner[c] = 0;
				spacing[c] = longint'(STEP_RESET);
			end
			pending_dist.delete();
			mismatches = 0;
			expected_left = 0;
			results_seen = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_HALF_SIZE: half_len = longint'(cfg_data[HALF_W-1:0]);
					REG_ORIGIN_X:  corner[0] = longint'($signed(cfg_data));
					REG_ORIGIN_Y:  corner[1] = longint'($signed(cfg_data));
					REG_ORIGIN_Z:  corner[2] = longint'($signed(cfg_data));
					REG_STEP_X:    spacing[0] = longint'(cfg_data[STEP_W-1:0]);
					REG_STEP_Y:    spacing[1] = longint'(cfg_data[STEP_W-1:0]);
					REG_STEP_Z:    spacing[2] = longint'(cfg_data[STEP_W-1:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pending_dist.size() == 0) begin
					report_mismatch($sformatf("unexpected result, distance %0d", distance));
				end else begin
					oldest = pending_dist.pop_front();
					if (distance !== oldest.dist_val)
						report_mismatch($sformatf("result %0d: distance %0d, expected %0d",
							results_seen, distance, oldest.dist_val));
					if (outside !== oldest.outside)
						report_mismatch($sformatf("result %0d: outside %b, expected %b",
							results_seen, outside, oldest.outside));
					if (saturated !== oldest.sat)
						report_mismatch($sformatf("result %0d: saturated %b, expected %b",
							results_seen, saturated, oldest.sat));
				end
				results_seen++;
			end
			if (in_valid && !in_stall)
				pending_dist.insert(pending_dist.size(),
					cube_distance(voxel_x, voxel_y, voxel_z));
			expected_left = pending_dist.size();
		end
	end

endmodule

@@ test/box_signed_distance_grid_tb.sv @@
// ----------------------------------------------------------------------------
// Box signed distance grid testbench
// Streams voxel index triples through the distance block under a series of
// cube and grid settings and idle patterns; a checker beside the block
// predicts every distance and flags any difference.
// ----------------------------------------------------------------------------
module box_signed_distance_grid_tb;
	import bsdg_pkg::*;

	// A run with no item moving on either channel for this many cycles is hung.
	// The limit lies far above the pipeline depth and the usual random gaps,
	// so this leaves a wide margin.
	localparam int QUIET_LIMIT   = 4000;
	// Cycles to keep watching after the last expected result, covering the
	// pipeline depth so that a stray extra result would still be seen.
	localparam int DRAIN_CYCLES  = 60;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 130;
	localparam logic [IDX_W-1:0] IDX_LAST = '1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [IDX_W-1:0]         voxel_x = '0;
	logic [IDX_W-1:0]         voxel_y = '0;
	logic [IDX_W-1:0]         voxel_z = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [DIST_W-1:0] distance;
	logic                     outside;
	logic                     saturated;

	int mismatches;
	int expected_left;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	box_signed_distance_grid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.distance  (distance),
		.outside   (outside),
		.saturated (saturated)
	);

	box_signed_distance_grid_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.voxel_x       (voxel_x),
		.voxel_y       (voxel_y),
		.voxel_z       (voxel_z),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.distance      (distance),
		.outside       (outside),
		.saturated     (saturated),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls at random with the probability of the current phase.
	// It is decided once per falling edge, so out_stall gets one update per step.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: any accepted item on either side restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Presents one voxel after a random number of idle cycles and holds it
	// until the block takes it. The stall is sampled at the rising edge, the
	// same edge at which the block accepts. The task is entered and left at a
	// falling edge, with valid still high so that back-to-back items leave
	// no gap unless the idle draw asks for one.
	task automatic send_voxel(input logic [IDX_W-1:0] x, input logic [IDX_W-1:0] y,
			input logic [IDX_W-1:0] z);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		voxel_x <= x;
		voxel_y <= y;
		voxel_z <= z;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drops valid and waits until every outstanding item has come back, so
	// that the registers may be changed. Every item yields exactly one
	// result, so an empty expectation store means the pipeline is empty.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_left != 0)
			@(negedge clk);
	endtask

	// Writes all seven registers on consecutive cycles. The write enable is
	// left high across the burst and lowered once at the end.
	task automatic load_registers(input logic [CFG_W-1:0] half,
			input logic [CFG_W-1:0] ox, input logic [CFG_W-1:0] oy,
			input logic [CFG_W-1:0] oz, input logic [CFG_W-1:0] sx,
			input logic [CFG_W-1:0] sy, input logic [CFG_W-1:0] sz);
		cfg_reg_t         which[7];
		logic [CFG_W-1:0] value[7];
		which = '{REG_HALF_SIZE, REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z,
			REG_STEP_X, REG_STEP_Y, REG_STEP_Z};
		value = '{half, ox, oy, oz, sx, sy, sz};
		for (int i = 0; i < 7; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= which[i];
			cfg_data <= value[i];
			@(negedge clk);
		end
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// A grid roughly centered on the cube with a cube that fills part of it,
	// so that points fall inside, on and beyond the surface.
	task automatic load_centered_grid();
		int unsigned st[3];
		int          org[3];
		int unsigned half;
		for (int c = 0; c < 3; c++) begin
			st[c] = $urandom_range(32'h100, 32'h4_0000);
			org[c] = -int'(st[c] * $urandom_range(16, 48));
		end
		half = $urandom_range(0, st[0] * 36);
		load_registers(half, org[0], org[1], org[2], st[0], st[1], st[2]);
	endtask

	// Every register takes one of its extreme values, zero step included.
	task automatic load_extreme_grid();
		logic [CFG_W-1:0] half_pick[3];
		logic [CFG_W-1:0] org_pick[3];
		logic [CFG_W-1:0] step_pick[3];
		half_pick = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001};
		org_pick = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
		step_pick = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF};
		load_registers(half_pick[2'($urandom_range(2))], org_pick[2'($urandom_range(2))],
			org_pick[2'($urandom_range(2))], org_pick[2'($urandom_range(2))],
			step_pick[2'($urandom_range(2))], step_pick[2'($urandom_range(2))],
			step_pick[2'($urandom_range(2))]);
	endtask

	// Grid indexes lean a little toward the first and last plane.
	function automatic logic [IDX_W-1:0] pick_index();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return IDX_LAST;
		return IDX_W'($urandom_range(IDX_LAST));
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed items with the reset setting: half size one, unit grid at the
		// origin. Center, a face point, a corner point (both on the surface),
		// just outside, and the far corner of the grid.
		send_voxel(0, 0, 0);
		send_voxel(1, 0, 0);
		send_voxel(1, 1, 1);
		send_voxel(2, 0, 0);
		send_voxel(0, 63, 2);
		send_voxel(63, 0, 0);
		send_voxel(63, 63, 63);
		wait_until_idle();

		// Degenerate cube at the most negative corner with the widest step:
		// the lowest corner gives an axis overshoot too large to represent,
		// high indexes overflow the coordinate range, and the root of the
		// combined overshoot saturates.
		load_registers(32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_voxel(0, 0, 0);
		send_voxel(63, 1, 1);
		send_voxel(63, 63, 63);
		wait_until_idle();

		// Largest cube, written with the unused top bit set, and a grid
		// collapsed onto its corner by a zero step: points on the surface,
		// and one axis a single unit beyond it.
		load_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_voxel(0, 0, 0);
		send_voxel(63, 63, 63);
		wait_until_idle();

		// Point-sized cube and the finest possible grid.
		load_registers(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send_voxel(0, 0, 0);
		send_voxel(63, 0, 0);
		send_voxel(42, 21, 63);
		wait_until_idle();

		// Random part. Each phase takes a new setting and one of four idle
		// patterns: none, sender idle, receiver stalling, or both at once.
		// Even phases use a centered grid, where inside and outside points
		// are mixed; odd ones alternate fully random and extreme settings.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 67;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 67;
				end
				default: begin
					idle_pct = 33;
					stall_pct = 33;
				end
			endcase
			if (phase % 2 == 0)
				load_centered_grid();
			else if (phase % 4 == 1)
				load_registers($urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			else
				load_extreme_grid();
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_voxel(pick_index(), pick_index(), pick_index());
			wait_until_idle();
		end

		// Keep the receiver free and watch a while longer for stray results.
		stall_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_left == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
